[src/tape_machine_instruction_step_macros.svh]
// Assertion macros shared by the tape machine checker
`ifndef TAPE_MACHINE_INSTRUCTION_STEP_MACROS_SVH
`define TAPE_MACHINE_INSTRUCTION_STEP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define TMIS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tape machine check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define TMIS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tape machine check failed");

`endif

[src/tmis_pkg.sv]
// Types and constants of the tape machine instruction stepper
package tmis_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_e;

  localparam logic [3:0] OP_CALL  = 4'd0;
  localparam logic [3:0] OP_IN    = 4'd1;
  localparam logic [3:0] OP_OUT   = 4'd2;
  localparam logic [3:0] OP_LEFT  = 4'd3;
  localparam logic [3:0] OP_RIGHT = 4'd4;
  localparam logic [3:0] OP_DEC   = 4'd5;
  localparam logic [3:0] OP_INC   = 4'd6;
  localparam logic [3:0] OP_RET   = 4'd9;
  localparam logic [3:0] OP_JUMP  = 4'd10;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_OPEN_CALL = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd3;

  localparam int unsigned PC_W   = 13;
  localparam int unsigned WORD_W = 25;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic acc;
    logic fire;
    logic clear;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic res_busy;
    logic is_start;
  } ctrl_sts_t;

endpackage

[src/tmis_ctrl.sv]
// Controller state machine of the tape machine stepper
module tmis_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  tmis_pkg::ctrl_sts_t sts_i,
  output tmis_pkg::ctrl_cmd_t ctrl_o
);
  import tmis_pkg::*;

  state_e state_q, state_d;

  // Hold state, start in a tape clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (!sts_i.res_busy) state_d = sts_i.is_start ? ST_CLEAR : ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    req_ready_o  = 1'b0;
    ctrl_o.acc   = 1'b0;
    ctrl_o.fire  = 1'b0;
    ctrl_o.clear = 1'b0;
    case (state_q)
      ST_CLEAR: ctrl_o.clear = 1'b1;
      ST_IDLE: begin
        req_ready_o = 1'b1;
        ctrl_o.acc  = req_valid_i;
      end
      ST_EXEC: ctrl_o.fire = !sts_i.res_busy;
      default: ;
    endcase
  end

endmodule

[src/tmis_datapath.sv]
// Datapath of the tape machine stepper: stores, machine registers, result register
module tmis_datapath #(
  parameter int unsigned TAPE_DEPTH    = 32768,
  parameter int unsigned CELL_WIDTH    = 8,
  parameter int unsigned PROGRAM_DEPTH = 4096,
  parameter int unsigned CALL_DEPTH    = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tmis_pkg::ctrl_cmd_t ctrl_i,
  output tmis_pkg::ctrl_sts_t sts_o,
  input  logic                cfg_valid_i,
  input  logic [12:0]         cfg_data_i,
  input  logic [1:0]          cmd_i,
  input  logic [11:0]         load_index_i,
  input  logic [3:0]          op_kind_i,
  input  logic                op_is_uncond_i,
  input  logic [7:0]          op_count_i,
  input  logic [11:0]         op_target_i,
  input  logic [7:0]          in_byte_i,
  input  logic                res_ready_i,
  output logic                res_valid_o,
  output logic                out_valid_o,
  output logic [7:0]          out_byte_o,
  output logic                input_requested_o,
  output logic                running_o,
  output logic [1:0]          error_code_o,
  output logic [12:0]         next_pc_o
);
  import tmis_pkg::*;

  localparam int unsigned AW  = $clog2(TAPE_DEPTH);
  localparam int unsigned CW  = CELL_WIDTH;
  localparam int unsigned PW  = $clog2(PROGRAM_DEPTH);
  localparam int unsigned DW  = $clog2(CALL_DEPTH + 1);
  localparam int unsigned SIW = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
  localparam logic [16:0] PDEPTH = 17'(PROGRAM_DEPTH);

  // Memories
  logic [WORD_W-1:0] prog_mem [PROGRAM_DEPTH];
  logic [CW-1:0]     tape_mem [TAPE_DEPTH];
  logic [PC_W-1:0]   stack_mem [CALL_DEPTH];

  // Machine state
  logic [12:0]     plen_q;
  logic [PC_W-1:0] pc_q, pc_d;
  logic [AW-1:0]   addr_q, addr_d;
  logic [7:0]      rep_q, rep_d;
  logic            await_q, await_d;
  logic            active_q, active_d;
  logic [DW-1:0]   depth_q, depth_d;
  logic [AW-1:0]   clr_q;
  cmd_e            cmd_q;

  // Read data of the current request
  logic [WORD_W-1:0] instr_q;
  logic [CW-1:0]     cell_rd_q;
  logic              fwd_q;
  logic [CW-1:0]     fwd_data_q;
  logic [PC_W-1:0]   top_q;

  // Result register
  logic            res_valid_q;
  logic            rv_q;
  logic [7:0]      rb_q;
  logic            rin_q;
  logic            rrun_q;
  logic [1:0]      rerr_q;
  logic [PC_W-1:0] rpc_q;

  // Combinational results of the execute cycle
  logic            ov_d, inreq_d;
  logic [7:0]      ob_d;
  logic [1:0]      err_d;
  logic            tape_we_x;
  logic [CW-1:0]   cell_new;
  logic            push_x;

  // Address helpers
  logic [PW+12:0]  pc_wide, ld_wide;
  logic [PW-1:0]   pc_idx, ld_idx;
  logic [DW-1:0]   depth_m1;
  logic [12:0]     eff_len;
  logic            await_wr;
  logic [CW-1:0]   cur_cell;
  logic [3:0]      kind;
  logic            uncond;
  logic [7:0]      count;
  logic [PC_W-1:0] target, pc_inc;
  logic [AW:0]     step_w;

  assign pc_wide  = {{PW{1'b0}}, pc_q};
  assign ld_wide  = {{(PW+1){1'b0}}, load_index_i};
  assign pc_idx   = pc_wide[PW-1:0];
  assign ld_idx   = ld_wide[PW-1:0];
  assign depth_m1 = depth_q - DW'(1);
  assign eff_len  = ({4'b0, plen_q} < PDEPTH) ? plen_q : PDEPTH[12:0];
  assign await_wr = ctrl_i.acc && (cmd_e'(cmd_i) == CMD_STEP) && active_q && await_q;

  assign cur_cell = fwd_q ? fwd_data_q : cell_rd_q;
  assign kind     = instr_q[3:0];
  assign uncond   = instr_q[4];
  assign count    = instr_q[12:5];
  assign target   = {1'b0, instr_q[24:13]};
  assign pc_inc   = pc_q + PC_W'(1);
  assign step_w   = (AW+1)'(count) + (AW+1)'(1);

  // Status
  assign sts_o.clear_last = (clr_q == AW'(TAPE_DEPTH - 1));
  assign sts_o.res_busy   = res_valid_q && !res_ready_i;
  assign sts_o.is_start   = (cmd_q == CMD_START);

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= '0;
    end else if (cfg_valid_i) begin
      plen_q <= cfg_data_i;
    end
  end

  // Program store: load at request, read the instruction at pc
  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc && cmd_e'(cmd_i) == CMD_LOAD) begin
      prog_mem[ld_idx] <= {op_target_i, op_count_i, op_is_uncond_i, op_kind_i};
    end
  end
  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc) instr_q <= prog_mem[pc_idx];
  end

  // Tape write: clearing sweep, pending input byte, or result of execute
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      tape_mem[clr_q] <= '0;
    end else if (await_wr) begin
      tape_mem[addr_q] <= CW'(in_byte_i);
    end else if (ctrl_i.fire && tape_we_x) begin
      tape_mem[addr_q] <= cell_new;
    end
  end
  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc) begin
      cell_rd_q  <= tape_mem[addr_q];
      fwd_q      <= await_wr;
      fwd_data_q <= CW'(in_byte_i);
    end
  end

  // Call stack: push on call, read the top at request
  always_ff @(posedge clk_i) begin
    if (ctrl_i.fire && push_x) stack_mem[depth_q[SIW-1:0]] <= pc_inc;
  end
  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc) top_q <= stack_mem[depth_m1[SIW-1:0]];
  end

  // Clear sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (ctrl_i.clear) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  // Execute one command
  always_comb begin
    pc_d      = pc_q;
    addr_d    = addr_q;
    rep_d     = rep_q;
    await_d   = await_q;
    active_d  = active_q;
    depth_d   = depth_q;
    ov_d      = 1'b0;
    ob_d      = '0;
    inreq_d   = 1'b0;
    err_d     = ERR_NONE;
    tape_we_x = 1'b0;
    cell_new  = cur_cell;
    push_x    = 1'b0;
    case (cmd_q)
      CMD_START: begin
        pc_d     = '0;
        addr_d   = '0;
        rep_d    = '0;
        await_d  = 1'b0;
        depth_d  = '0;
        active_d = 1'b1;
      end
      CMD_STOP: active_d = 1'b0;
      CMD_STEP: begin
        if (active_q) begin
          await_d = 1'b0;
          if (pc_q >= eff_len) begin
            active_d = 1'b0;
            if (depth_q != '0) err_d = ERR_OPEN_CALL;
          end else begin
            case (kind)
              OP_CALL: begin
                if (depth_q >= DW'(CALL_DEPTH)) begin
                  err_d = ERR_OVERFLOW;
                end else begin
                  push_x  = 1'b1;
                  depth_d = depth_q + DW'(1);
                  pc_d    = target;
                end
              end
              OP_IN, OP_OUT: begin
                if (kind == OP_IN) begin
                  inreq_d = 1'b1;
                  await_d = 1'b1;
                end else begin
                  ov_d = 1'b1;
                  ob_d = cur_cell[7:0];
                end
                if (count > rep_q) begin
                  rep_d = rep_q + 8'd1;
                end else begin
                  rep_d = '0;
                  pc_d  = pc_inc;
                end
              end
              OP_LEFT: begin
                addr_d = addr_q - step_w[AW-1:0];
                pc_d   = pc_inc;
              end
              OP_RIGHT: begin
                addr_d = addr_q + step_w[AW-1:0];
                pc_d   = pc_inc;
              end
              OP_DEC: begin
                tape_we_x = 1'b1;
                cell_new  = cur_cell - CW'(count) - CW'(1);
                pc_d      = pc_inc;
              end
              OP_INC: begin
                tape_we_x = 1'b1;
                cell_new  = cur_cell + CW'(count) + CW'(1);
                pc_d      = pc_inc;
              end
              OP_RET: begin
                if (depth_q == '0) begin
                  err_d = ERR_UNDERFLOW;
                end else begin
                  depth_d = depth_m1;
                  pc_d    = top_q;
                end
              end
              OP_JUMP: pc_d = (uncond || cur_cell == '0) ? target : pc_inc;
              default: pc_d = pc_inc;
            endcase
            if (err_d != ERR_NONE) begin
              active_d = 1'b0;
            end else if (pc_d >= eff_len) begin
              active_d = 1'b0;
              if (depth_d != '0) err_d = ERR_OPEN_CALL;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Machine registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= '0;
      addr_q   <= '0;
      rep_q    <= '0;
      await_q  <= 1'b0;
      active_q <= 1'b0;
      depth_q  <= '0;
      cmd_q    <= CMD_LOAD;
    end else begin
      if (ctrl_i.acc) cmd_q <= cmd_e'(cmd_i);
      if (ctrl_i.fire) begin
        pc_q     <= pc_d;
        addr_q   <= addr_d;
        rep_q    <= rep_d;
        await_q  <= await_d;
        active_q <= active_d;
        depth_q  <= depth_d;
      end
    end
  end

  // Result register: fill on execute, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (ctrl_i.fire) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (ctrl_i.fire) begin
      rv_q   <= ov_d;
      rb_q   <= ob_d;
      rin_q  <= inreq_d;
      rrun_q <= active_d;
      rerr_q <= err_d;
      rpc_q  <= pc_d;
    end
  end

  assign res_valid_o       = res_valid_q;
  assign out_valid_o       = rv_q;
  assign out_byte_o        = rb_q;
  assign input_requested_o = rin_q;
  assign running_o         = rrun_q;
  assign error_code_o      = rerr_q;
  assign next_pc_o         = rpc_q;

endmodule

[src/tape_machine_instruction_step.sv]
// A request is accepted and its program, tape and stack reads are registered,
// then it executes once the result register is free. A new request is taken
// only after the previous one has executed. Reset and start each run a tape
// clearing sweep over all TAPE_DEPTH cells, one cell a cycle, with no request
// taken; depths must be powers of two, which the block does not enforce.
module tape_machine_instruction_step #(
  parameter int unsigned TAPE_DEPTH    = 32768,
  parameter int unsigned CELL_WIDTH    = 8,
  parameter int unsigned PROGRAM_DEPTH = 4096,
  parameter int unsigned CALL_DEPTH    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [12:0] cfg_data_i,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [11:0] load_index_i,
  input  logic [3:0]  op_kind_i,
  input  logic        op_is_uncond_i,
  input  logic [7:0]  op_count_i,
  input  logic [11:0] op_target_i,
  input  logic [7:0]  in_byte_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic        out_valid_o,
  output logic [7:0]  out_byte_o,
  output logic        input_requested_o,
  output logic        running_o,
  output logic [1:0]  error_code_o,
  output logic [12:0] next_pc_o
);
  import tmis_pkg::*;

  ctrl_cmd_t ctrl;
  ctrl_sts_t sts;

  assign cfg_ready_o = 1'b1;

  tmis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .sts_i       (sts),
    .ctrl_o      (ctrl)
  );

  tmis_datapath #(
    .TAPE_DEPTH    (TAPE_DEPTH),
    .CELL_WIDTH    (CELL_WIDTH),
    .PROGRAM_DEPTH (PROGRAM_DEPTH),
    .CALL_DEPTH    (CALL_DEPTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .sts_o             (sts),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_data_i        (cfg_data_i),
    .cmd_i             (cmd_i),
    .load_index_i      (load_index_i),
    .op_kind_i         (op_kind_i),
    .op_is_uncond_i    (op_is_uncond_i),
    .op_count_i        (op_count_i),
    .op_target_i       (op_target_i),
    .in_byte_i         (in_byte_i),
    .res_ready_i       (res_ready_i),
    .res_valid_o       (res_valid_o),
    .out_valid_o       (out_valid_o),
    .out_byte_o        (out_byte_o),
    .input_requested_o (input_requested_o),
    .running_o         (running_o),
    .error_code_o      (error_code_o),
    .next_pc_o         (next_pc_o)
  );

endmodule

[src/tmis_checker.sv]
// Port-level checks of the tape machine stepper, bound to the top level
`include "tape_machine_instruction_step_macros.svh"

module tmis_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_o,
  input logic        res_ready_i,
  input logic        out_valid_o,
  input logic        input_requested_o,
  input logic        running_o,
  input logic [1:0]  error_code_o,
  input logic [12:0] next_pc_o
);
  import tmis_pkg::*;

  // A faulted program never reports itself as running
  `TMIS_ASSERT_IMP(a_err_halts, res_valid_o && error_code_o != ERR_NONE, !running_o)
  // Output and input request come from different instructions
  `TMIS_ASSERT_IMP(a_io_excl, res_valid_o, !(out_valid_o && input_requested_o))
  // Hold a stalled result
  `TMIS_ASSERT_NXT(a_res_hold, res_valid_o && !res_ready_i, res_valid_o)
  `TMIS_ASSERT_NXT(a_pc_hold, res_valid_o && !res_ready_i, $stable(next_pc_o))

endmodule

bind tape_machine_instruction_step tmis_checker u_tmis_checker (.*);
